FILE: design/rrts_pkg.sv
// ---------------------------------------------------------------------------
// rrts_pkg
// types, slot state codes and operation codes for the thread scheduler
// ---------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_SLEEPING = 3'd4,
    ST_DEAD     = 3'd5
  } slot_st_t;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_ADD   = 3'd1,
    FN_YIELD = 3'd2,
    FN_BLOCK = 3'd3,
    FN_WAKE  = 3'd4,
    FN_SLEEP = 3'd5,
    FN_EXIT  = 3'd6,
    FN_NONE  = 3'd7
  } func_t;

  localparam logic [0:0] CFG_QUANTUM = 1'b0;
  localparam logic [0:0] CFG_TPS     = 1'b1;
  localparam int unsigned MS_PER_SECOND = 1000;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [3:0]  queue_id;
    logic [31:0] delay_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] running_slot;
    logic [3:0] previous_slot;
    logic       switched;
    logic [4:0] reaped_count;
    logic       status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_DIV, S_WAKE, S_QWAKE, S_REAP, S_PICK, S_COMMIT, S_OUT
  } seq_st_t;

endpackage

FILE: design/rrts_div.sv
// ---------------------------------------------------------------------------
// rrts_div
// sleep length in ticks: ms times tick rate over 1000, by reciprocal multiply
// on one shared 32x32 multiplier, eight steps after start
// ---------------------------------------------------------------------------
module rrts_div
  import rrts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] ms,
  input  logic [13:0] tps,
  output logic        done,
  output logic [45:0] quotient
);

  // 2^38 / 1000 rounded up: exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP_1000 = 32'h1062_4DD3;

  logic [31:0] ms_r, ms_nxt;
  logic [13:0] tps_r, tps_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [22:0] qm_r, qm_nxt;
  logic [9:0]  rm_r, rm_nxt;
  logic [13:0] ql_r, ql_nxt;
  logic [45:0] sum_r, sum_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign done     = done_r;
  assign quotient = sum_r;

  // ms*tps/1000 = (ms/1000)*tps + ((ms%1000)*tps)/1000
  always_comb begin
    ms_nxt   = ms_r;
    tps_nxt  = tps_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    qm_nxt   = qm_r;
    rm_nxt   = rm_r;
    ql_nxt   = ql_r;
    sum_nxt  = sum_r;
    mul_a    = '0;
    mul_b    = '0;
    if (start) begin
      ms_nxt   = ms;
      tps_nxt  = tps;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      case (step_r)
        3'd0: begin
          mul_a    = ms_r;
          mul_b    = RECIP_1000;
          prod_nxt = mul_p;
        end
        3'd1: qm_nxt = prod_r[60:38];
        3'd2: begin
          mul_a    = 32'(qm_r);
          mul_b    = 32'(MS_PER_SECOND);
          prod_nxt = mul_p;
        end
        // remainder is below 1000, so ten bits carry it
        3'd3: rm_nxt = ms_r[9:0] - prod_r[9:0];
        3'd4: begin
          mul_a    = 32'(rm_r);
          mul_b    = 32'(tps_r);
          prod_nxt = mul_p;
        end
        3'd5: begin
          mul_a    = prod_r[31:0];
          mul_b    = RECIP_1000;
          prod_nxt = mul_p;
        end
        3'd6: begin
          ql_nxt   = prod_r[51:38];
          mul_a    = 32'(qm_r);
          mul_b    = 32'(tps_r);
          prod_nxt = mul_p;
        end
        3'd7: begin
          sum_nxt  = prod_r[45:0] + 46'(ql_r);
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    ms_r   <= ms_nxt;
    tps_r  <= tps_nxt;
    prod_r <= prod_nxt;
    qm_r   <= qm_nxt;
    rm_r   <= rm_nxt;
    ql_r   <= ql_nxt;
    sum_r  <= sum_nxt;
  end

endmodule

FILE: design/round_robin_thread_scheduler_core.sv
// ---------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// ring-based round-robin scheduler with time quantum, one slot per cycle walk
// ---------------------------------------------------------------------------
// usage: one input word per operation (tick, add, yield, block, wake queue,
// sleep, exit). each word gives exactly one result word.
// in_stall is high from acceptance until the sequencer is back in idle; one
// word is worked on at a time.
// path, from acceptance to out_valid: add and unknown codes go straight
// from decode to output; wake queue scans every slot; tick walks the ring
// for wakes and, with a pass, then does the reap walk and pick walk; yield,
// block and exit do the reap walk and pick walk; sleep first does the divide
// by 1000 on the shared multiplier, then the reap walk and pick walk.
// a new word is taken the cycle after its result is registered.
// the result sits in an output register; while out_stall holds it the next
// word is still taken and worked on, and its result waits in the last state
// until the register is free.
// reset: slot 0 running, idle slot ready, ring 0 -> idle -> 0, time zero,
// quantum 5, ticks per second 100. cfg writes are taken at any time but
// meant for idle periods only.
// ---------------------------------------------------------------------------
module round_robin_thread_scheduler_core
  import rrts_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int QUEUES    = 16,
  parameter int IDLE_SLOT = 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [13:0] cfg_wdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] IDLE_IDX = SW'(IDLE_SLOT % SLOTS);

  slot_st_t      st_r   [SLOTS];
  logic [SW-1:0] nxt_r  [SLOTS];
  logic [63:0]   wake_r [SLOTS];
  logic [QW-1:0] wq_r   [SLOTS];

  logic [7:0]  quantum_r;
  logic [13:0] tps_r;
  logic [SW-1:0] run_r, before_r, prev_r, t_r, pick_r;
  logic [7:0]  left_r;
  logic [63:0] time_r;
  logic [CW-1:0] guard_r, freed_r;
  logic        found_r;
  logic        status_r;
  in_word_t    cmd_r;
  out_word_t   out_r;
  logic        out_valid_r;
  logic        out_load;
  seq_st_t     seq_r, seq_nxt;
  logic        div_start;
  logic        div_done;
  logic [45:0] div_q;
  logic [QW-1:0] qid;
  logic [QW-1:0] qmod_tab [16];

  // queue number folded into range, one entry per possible queue_id
  always_comb begin
    for (int i = 0; i < 16; i++) qmod_tab[i] = QW'(i % QUEUES);
  end

  assign qid = qmod_tab[cmd_r.queue_id];

  rrts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .ms(cmd_r.delay_ms), .tps(tps_r),
    .done(div_done), .quotient(div_q)
  );

  assign in_stall  = (seq_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (seq_r == S_OUT) && (!out_valid_r || !out_stall);

  logic add_ok;
  assign add_ok = (32'(cmd_r.slot) < SLOTS) && (st_r[SW'(cmd_r.slot)] == ST_FREE);

  logic needs_pass;
  assign needs_pass = (cmd_r.func != FN_TICK) || (left_r <= 8'd1);

  always_comb begin
    seq_nxt   = seq_r;
    div_start = 1'b0;
    unique case (seq_r)
      S_IDLE:   if (in_valid && !in_stall) seq_nxt = S_DECODE;
      S_DECODE: begin
        unique case (func_t'(cmd_r.func))
          FN_TICK:  seq_nxt = S_WAKE;
          FN_SLEEP: seq_nxt = S_MUL;
          FN_WAKE:  seq_nxt = S_QWAKE;
          FN_YIELD, FN_BLOCK, FN_EXIT: seq_nxt = S_REAP;
          default:  seq_nxt = S_OUT;
        endcase
      end
      S_MUL:    begin seq_nxt = S_DIV; div_start = 1'b1; end
      S_DIV:    if (div_done) seq_nxt = S_REAP;
      S_WAKE:   if (32'(guard_r) == SLOTS - 1 || nxt_r[t_r] == run_r)
                  seq_nxt = needs_pass ? S_REAP : S_OUT;
      S_QWAKE:  if (32'(guard_r) == SLOTS - 1) seq_nxt = S_OUT;
      S_REAP:   if (t_r == run_r || 32'(guard_r) == SLOTS) seq_nxt = S_PICK;
      S_PICK:   if (found_r || t_r == run_r || 32'(guard_r) == SLOTS)
                  seq_nxt = S_COMMIT;
      S_COMMIT: seq_nxt = S_OUT;
      S_OUT:    if (out_load) seq_nxt = S_IDLE;
      default:  seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      quantum_r   <= 8'd5;
      tps_r       <= 14'd100;
      run_r       <= '0;
      left_r      <= 8'd5;
      time_r      <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (i == 0)                  st_r[i] <= ST_RUNNING;
        else if (SW'(i) == IDLE_IDX) st_r[i] <= ST_READY;
        else                         st_r[i] <= ST_FREE;
        nxt_r[i]  <= (i == 0) ? IDLE_IDX : '0;
        wake_r[i] <= '0;
        wq_r[i]   <= '0;
      end
    end else begin
      seq_r <= seq_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_QUANTUM) quantum_r <= cfg_wdata[7:0];
        else                          tps_r     <= cfg_wdata;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (seq_r)
        S_IDLE: if (in_valid && !in_stall) begin
          cmd_r    <= in_data;
          before_r <= run_r;
          freed_r  <= '0;
          guard_r  <= '0;
          t_r      <= run_r;
          found_r  <= 1'b0;
          status_r <= 1'b0;
        end
        S_DECODE: begin
          prev_r  <= run_r;
          t_r     <= (cmd_r.func == FN_TICK) ? run_r : nxt_r[run_r];
          guard_r <= '0;
          unique case (func_t'(cmd_r.func))
            FN_TICK: time_r <= time_r + 64'd1;
            FN_ADD: begin
              if (add_ok) begin
                nxt_r[SW'(cmd_r.slot)] <= nxt_r[run_r];
                nxt_r[run_r]          <= SW'(cmd_r.slot);
                st_r[SW'(cmd_r.slot)] <= ST_READY;
              end else status_r <= 1'b1;
            end
            FN_BLOCK: begin
              wq_r[run_r] <= qid;
              st_r[run_r] <= ST_BLOCKED;
            end
            FN_EXIT: if (run_r != IDLE_IDX) st_r[run_r] <= ST_DEAD;
            default: ;
          endcase
        end
        S_MUL: ;
        S_DIV: if (div_done) begin
          // sleep is at least one tick when nonzero
          wake_r[run_r] <= time_r + ((div_q == '0 && cmd_r.delay_ms != '0) ?
                           64'd1 : 64'(div_q));
          st_r[run_r]   <= ST_SLEEPING;
        end
        S_WAKE: begin
          if (st_r[t_r] == ST_SLEEPING && time_r >= wake_r[t_r]) st_r[t_r] <= ST_READY;
          if (seq_nxt == S_WAKE) begin
            t_r     <= nxt_r[t_r];
            guard_r <= guard_r + CW'(1);
          end else if (needs_pass) begin
            left_r  <= 8'd0;
            t_r     <= nxt_r[run_r];
            prev_r  <= run_r;
            guard_r <= '0;
          end else left_r <= left_r - 8'd1;
        end
        S_QWAKE: begin
          if (st_r[guard_r[SW-1:0]] == ST_BLOCKED && wq_r[guard_r[SW-1:0]] == qid)
            st_r[guard_r[SW-1:0]] <= ST_READY;
          guard_r <= guard_r + CW'(1);
        end
        S_REAP: begin
          if (t_r == run_r || 32'(guard_r) == SLOTS) begin
            t_r     <= nxt_r[run_r];
            guard_r <= '0;
          end else begin
            guard_r <= guard_r + CW'(1);
            if (st_r[t_r] == ST_DEAD) begin
              // unlink and retry from the same predecessor
              nxt_r[prev_r] <= nxt_r[t_r];
              st_r[t_r]     <= ST_FREE;
              freed_r       <= freed_r + CW'(1);
              t_r           <= nxt_r[t_r];
            end else begin
              prev_r <= t_r;
              t_r    <= nxt_r[t_r];
            end
          end
        end
        S_PICK: begin
          if (t_r != run_r && 32'(guard_r) != SLOTS && t_r != IDLE_IDX &&
              st_r[t_r] == ST_READY) begin
            found_r <= 1'b1;
            pick_r  <= t_r;
          end else if (t_r == run_r || 32'(guard_r) == SLOTS) begin
            pick_r <= (st_r[run_r] == ST_RUNNING) ? run_r : IDLE_IDX;
          end else begin
            t_r     <= nxt_r[t_r];
            guard_r <= guard_r + CW'(1);
          end
        end
        S_COMMIT: begin
          left_r <= quantum_r;
          if (pick_r == run_r) st_r[run_r] <= ST_RUNNING;
          else begin
            if (st_r[run_r] == ST_RUNNING) st_r[run_r] <= ST_READY;
            st_r[pick_r] <= ST_RUNNING;
            run_r        <= pick_r;
          end
        end
        S_OUT: if (out_load) begin
          out_r.running_slot  <= 4'(run_r);
          out_r.previous_slot <= 4'(before_r);
          out_r.switched      <= run_r != before_r;
          out_r.reaped_count  <= 5'(freed_r);
          out_r.status        <= status_r;
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_OUT) |=> out_valid) else $error("result not raised");
  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == S_IDLE) |-> (st_r[run_r] == ST_RUNNING || st_r[run_r] == ST_BLOCKED ||
     st_r[run_r] == ST_SLEEPING || st_r[run_r] == ST_DEAD))
    else $error("current slot in bad state");

endmodule
